// ----- rtl/cpes_pkg.sv -----
// Shared types, constants and helper functions for the charged particle Euler step block.
package cpes_pkg;

    // Number format: signed Q16.16 values.
    localparam int VALUE_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int AXES          = 3;

    // Tick length is unsigned Q12.4 milliseconds.
    localparam int DT_WIDTH      = 16;
    localparam int MS_PER_SECOND = 1000;
    localparam int DT_FRAC_BITS  = 4;
    localparam int DT_DIVISOR    = (1 << DT_FRAC_BITS) * MS_PER_SECOND;

    // Datapath widths.
    localparam int PROD_WIDTH    = 2 * VALUE_WIDTH;
    localparam int SHIFTED_WIDTH = PROD_WIDTH - FRACTION_BITS;
    localparam int SCALE_WIDTH   = VALUE_WIDTH + DT_WIDTH;
    localparam int SAT_WIDTH     = (SHIFTED_WIDTH > SCALE_WIDTH) ? SHIFTED_WIDTH : SCALE_WIDTH;
    localparam int REM_WIDTH     = $clog2(DT_DIVISOR);
    localparam int DIGIT_BITS    = 4;
    localparam int CUR_WIDTH     = REM_WIDTH + DIGIT_BITS;
    localparam int DIV_STEPS     = SCALE_WIDTH / DIGIT_BITS;
    localparam int LANES         = 2 * AXES;

    // Tick sequence layout.
    localparam int STEP_WIDTH = 5;
    localparam int DIV_FIRST  = 13;
    localparam int DIV_LAST   = DIV_FIRST + DIV_STEPS - 1;
    localparam int STEP_DSAT  = DIV_LAST + 1;
    localparam int STEP_DADD  = DIV_LAST + 2;
    localparam int TICK_LAST  = STEP_DADD;

    // Configuration port.
    localparam int ADDR_WIDTH    = 3;
    localparam int CFG_IDX_WIDTH = 1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_CHARGE   = 1'b0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_INV_MASS = 1'b1;
    localparam logic [VALUE_WIDTH-2:0]   INV_MASS_RESET = (VALUE_WIDTH-1)'(1) << FRACTION_BITS;

    // Request modes.
    localparam logic [2:0] MODE_ADD_FORCE = 3'd0;
    localparam logic [2:0] MODE_ADD_EFIELD = 3'd1;
    localparam logic [2:0] MODE_ADD_BFIELD = 3'd2;
    localparam logic [2:0] MODE_TICK       = 3'd3;
    localparam logic [2:0] MODE_LOAD_POS   = 3'd4;
    localparam logic [2:0] MODE_LOAD_VEL   = 3'd5;
    localparam logic [2:0] MODE_LOAD_ACC   = 3'd6;

    localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [2:0]                    mode;
        logic signed [VALUE_WIDTH-1:0] vec_x;
        logic signed [VALUE_WIDTH-1:0] vec_y;
        logic signed [VALUE_WIDTH-1:0] vec_z;
        logic [DT_WIDTH-1:0]           dt_ms;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] pos_x;
        logic signed [VALUE_WIDTH-1:0] pos_y;
        logic signed [VALUE_WIDTH-1:0] pos_z;
        logic signed [VALUE_WIDTH-1:0] vel_x;
        logic signed [VALUE_WIDTH-1:0] vel_y;
        logic signed [VALUE_WIDTH-1:0] vel_z;
        logic signed [VALUE_WIDTH-1:0] acc_x;
        logic signed [VALUE_WIDTH-1:0] acc_y;
        logic signed [VALUE_WIDTH-1:0] acc_z;
        logic                          saturated;
    } out_item_t;

    // Multiplier operand A selection.
    typedef enum logic [3:0] {
        A_NONE, A_VEL0, A_VEL1, A_VEL2, A_ACC0, A_ACC1, A_ACC2, A_CHG, A_F0, A_F1, A_F2
    } opa_t;

    // Multiplier operand B selection.
    typedef enum logic [2:0] {
        B_B0, B_B1, B_B2, B_DT, B_CR0, B_CR1, B_CR2, B_IM
    } opb_t;

    // Where the product of the previous step goes.
    typedef enum logic [4:0] {
        P_NONE, P_T, P_CR0, P_CR1, P_CR2, P_F0, P_F1, P_F2, P_ACC0, P_ACC1, P_ACC2,
        P_W0, P_W1, P_W2, P_W3, P_W4, P_W5
    } post_t;

    // Operation applied to all lanes at once.
    typedef enum logic [2:0] {
        L_NONE, L_ADDE, L_DIV, L_DSAT, L_DADD
    } lane_t;

    typedef struct packed {
        opa_t  a;
        opb_t  b;
        post_t post;
        lane_t lane;
    } uop_t;

    localparam uop_t UOP_NOP = '{a: A_NONE, b: B_B0, post: P_NONE, lane: L_NONE};

    // Controller to datapath command.
    typedef struct packed {
        logic accept;
        logic emit;
        uop_t uop;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic is_tick;
    } stat_t;

    typedef struct packed {
        logic                          sat;
        logic signed [VALUE_WIDTH-1:0] val;
    } sat_val_t;

    // One lane of the divide by DT_DIVISOR: quotient shifts in from the bottom.
    typedef struct packed {
        logic                   neg;
        logic [SCALE_WIDTH-1:0] quo;
        logic [REM_WIDTH-1:0]   rem;
    } div_lane_t;

    // Magnitude of a signed value; the most negative value maps to 2^(N-1).
    function automatic logic [VALUE_WIDTH-1:0] magn(input logic signed [VALUE_WIDTH-1:0] x);
        return x[VALUE_WIDTH-1] ? ((~x) + VALUE_WIDTH'(1)) : x;
    endfunction

    function automatic sat_val_t sat_add(input logic signed [VALUE_WIDTH-1:0] a,
                                         input logic signed [VALUE_WIDTH-1:0] b);
        logic [VALUE_WIDTH:0] s;
        sat_val_t r;
        s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
        r.sat = s[VALUE_WIDTH] ^ s[VALUE_WIDTH-1];
        r.val = r.sat ? (s[VALUE_WIDTH] ? VMIN : VMAX) : s[VALUE_WIDTH-1:0];
        return r;
    endfunction

    function automatic sat_val_t sat_sub(input logic signed [VALUE_WIDTH-1:0] a,
                                         input logic signed [VALUE_WIDTH-1:0] b);
        logic [VALUE_WIDTH:0] s;
        sat_val_t r;
        s = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
        r.sat = s[VALUE_WIDTH] ^ s[VALUE_WIDTH-1];
        r.val = r.sat ? (s[VALUE_WIDTH] ? VMIN : VMAX) : s[VALUE_WIDTH-1:0];
        return r;
    endfunction

    // Turn a magnitude and a sign into a clipped signed value.
    function automatic sat_val_t sat_mag(input logic [SAT_WIDTH-1:0] m, input logic neg);
        logic [SAT_WIDTH-1:0] lim;
        sat_val_t r;
        lim = (SAT_WIDTH'(1) << (VALUE_WIDTH - 1)) - SAT_WIDTH'(!neg);
        if (m > lim) begin
            r.sat = 1'b1;
            r.val = neg ? VMIN : VMAX;
        end else begin
            r.sat = 1'b0;
            r.val = neg ? ((~m[VALUE_WIDTH-1:0]) + VALUE_WIDTH'(1)) : m[VALUE_WIDTH-1:0];
        end
        return r;
    endfunction

    // One radix-16 digit of the long division by DT_DIVISOR.
    function automatic div_lane_t div_step(input div_lane_t l);
        logic [CUR_WIDTH-1:0]  cur;
        logic [CUR_WIDTH-1:0]  sub;
        logic [DIGIT_BITS-1:0] d;
        div_lane_t r;
        cur = {l.rem, l.quo[SCALE_WIDTH-1 -: DIGIT_BITS]};
        d   = '0;
        sub = '0;
        for (int k = 1; k < (1 << DIGIT_BITS); k++) begin
            if (cur >= CUR_WIDTH'(k * DT_DIVISOR)) begin
                d   = DIGIT_BITS'(k);
                sub = CUR_WIDTH'(k * DT_DIVISOR);
            end
        end
        r.neg = l.neg;
        r.quo = {l.quo[SCALE_WIDTH-DIGIT_BITS-1:0], d};
        r.rem = REM_WIDTH'(cur - sub);
        return r;
    endfunction

    // Tick microprogram: one multiply issued per step, its result placed one step later.
    function automatic uop_t tick_uop(input logic [STEP_WIDTH-1:0] step);
        uop_t u;
        u = UOP_NOP;
        case (step)
            5'd0: begin
                u.a = A_VEL1; u.b = B_B2;
            end
            5'd1: begin
                u.a = A_VEL2; u.b = B_B1; u.post = P_T;
            end
            5'd2: begin
                u.a = A_VEL2; u.b = B_B0; u.post = P_CR0;
            end
            5'd3: begin
                u.a = A_VEL0; u.b = B_B2; u.post = P_T;
            end
            5'd4: begin
                u.a = A_VEL0; u.b = B_B1; u.post = P_CR1;
            end
            5'd5: begin
                u.a = A_VEL1; u.b = B_B0; u.post = P_T;
            end
            5'd6: begin
                u.a = A_VEL0; u.b = B_DT; u.post = P_CR2;
            end
            5'd7: begin
                u.a = A_VEL1; u.b = B_DT; u.post = P_W0; u.lane = L_ADDE;
            end
            5'd8: begin
                u.a = A_VEL2; u.b = B_DT; u.post = P_W1;
            end
            5'd9: begin
                u.a = A_ACC0; u.b = B_DT; u.post = P_W2;
            end
            5'd10: begin
                u.a = A_ACC1; u.b = B_DT; u.post = P_W3;
            end
            5'd11: begin
                u.a = A_ACC2; u.b = B_DT; u.post = P_W4;
            end
            5'd12: begin
                u.a = A_CHG; u.b = B_CR0; u.post = P_W5;
            end
            5'd13: begin
                u.a = A_CHG; u.b = B_CR1; u.post = P_F0;
            end
            5'd14: begin
                u.a = A_CHG; u.b = B_CR2; u.post = P_F1;
            end
            5'd15: begin
                u.a = A_F0; u.b = B_IM; u.post = P_F2;
            end
            5'd16: begin
                u.a = A_F1; u.b = B_IM; u.post = P_ACC0;
            end
            5'd17: begin
                u.a = A_F2; u.b = B_IM; u.post = P_ACC1;
            end
            5'd18: begin
                u.post = P_ACC2;
            end
            default: ;
        endcase
        if (step inside {[DIV_FIRST:DIV_LAST]}) begin
            u.lane = L_DIV;
        end else if (step == STEP_WIDTH'(STEP_DSAT)) begin
            u.lane = L_DSAT;
        end else if (step == STEP_WIDTH'(STEP_DADD)) begin
            u.lane = L_DADD;
        end
        return u;
    endfunction

endpackage

// ----- rtl/charged_particle_euler_step.sv -----
// Top level of the charged particle Euler step block: configuration registers and assembly.
//
// Usage: requests arrive on the s_ channel (valid/ready) and carry a mode and a vector.
// Add, load and unused-mode requests are applied at the edge where they are accepted,
// so, with no tick in progress, the block takes one per cycle; they produce no result.
// A tick request produces one result on the m_ channel holding the new position,
// velocity and acceleration plus a flag that reports any clipping during the tick.
// A tick steps through its microprogram after its accept edge, then loads the output
// register once that register is free; m_valid rises at the edge that loads it, and the
// next request can be taken in that same cycle. The tick length is set by the single
// shared 32x32 multiplier (18 products, one per cycle) and by the 12-digit radix-16
// divide by 16000 that scales the velocity and acceleration by the time step.
// A finished result waits in the output register while the receiver stalls; the block
// keeps taking add and load requests, but a later tick holds before loading its result.
// Reset (aresetn low, synchronous) zeroes position, velocity, acceleration and the
// accumulators, drops m_valid, and sets charge to 0 and inverse mass to 1.0. The APB-style
// port holds charge at address 0 and inverse mass at address 4; pready is always high.
module charged_particle_euler_step
    import cpes_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_WIDTH-1:0]  paddr,
    input  logic [VALUE_WIDTH-1:0] pwdata,
    output logic [VALUE_WIDTH-1:0] prdata,
    output logic                   pready
);

    logic signed [VALUE_WIDTH-1:0] charge_reg;
    logic [VALUE_WIDTH-2:0]        inv_mass_reg;
    logic [CFG_IDX_WIDTH-1:0]      cfg_idx;
    cmd_t                          ctrl_cmd;
    stat_t                         dp_stat;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_WIDTH-1:2];

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            charge_reg   <= '0;
            inv_mass_reg <= INV_MASS_RESET;
        end else if (psel && penable && pwrite) begin
            case (cfg_idx)
                CFG_CHARGE:   charge_reg   <= pwdata;
                CFG_INV_MASS: inv_mass_reg <= pwdata[VALUE_WIDTH-2:0];
                default: ;
            endcase
        end
    end

    // Configuration register reads.
    always_comb begin
        case (cfg_idx)
            CFG_CHARGE:   prdata = charge_reg;
            CFG_INV_MASS: prdata = {1'b0, inv_mass_reg};
            default:      prdata = '0;
        endcase
    end

    cpes_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (dp_stat),
        .cmd     (ctrl_cmd)
    );

    cpes_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (ctrl_cmd),
        .s_data   (s_data),
        .charge   (charge_reg),
        .inv_mass (inv_mass_reg),
        .stat     (dp_stat),
        .m_data   (m_data)
    );

    // An accepted tick request keeps the input closed while it runs.
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.mode == MODE_TICK) |=> !s_ready)
        else $error("input open right after a tick request was accepted");

    // Requests other than a tick never raise a result.
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.mode != MODE_TICK && !m_valid) |=> !m_valid)
        else $error("result raised by a request that is not a tick");

    // Loading a result presents it and reopens the input.
    a_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.emit |=> (m_valid && s_ready))
        else $error("result load did not present the result and reopen the input");

endmodule

// ----- rtl/cpes_ctrl.sv -----
// Controller: accepts requests, sequences the tick microprogram and owns the result valid.
module cpes_ctrl
    import cpes_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    output logic  m_valid,
    input  logic  m_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [STEP_WIDTH-1:0]   step_reg, step_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    // Next state and command decode.
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.accept   = 1'b0;
        cmd.emit     = 1'b0;
        cmd.uop      = UOP_NOP;
        case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_valid;
                if (s_valid && stat.is_tick) begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN: begin
                cmd.uop = tick_uop(step_reg);
                if (step_reg == STEP_WIDTH'(TICK_LAST)) begin
                    state_next = ST_EMIT;
                end else begin
                    step_next = step_reg + STEP_WIDTH'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- rtl/cpes_datapath.sv -----
// Datapath: particle state, accumulators, shared multiplier and divide-by-constant lanes.
module cpes_datapath
    import cpes_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cmd_t                          cmd,
    input  in_item_t                      s_data,
    input  logic signed [VALUE_WIDTH-1:0] charge,
    input  logic [VALUE_WIDTH-2:0]        inv_mass,
    output stat_t                         stat,
    output out_item_t                     m_data
);

    logic signed [VALUE_WIDTH-1:0] pos_reg [AXES], pos_next [AXES];
    logic signed [VALUE_WIDTH-1:0] vel_reg [AXES], vel_next [AXES];
    logic signed [VALUE_WIDTH-1:0] acc_reg [AXES], acc_next [AXES];
    logic signed [VALUE_WIDTH-1:0] frc_reg [AXES], frc_next [AXES];
    logic signed [VALUE_WIDTH-1:0] efs_reg [AXES], efs_next [AXES];
    logic signed [VALUE_WIDTH-1:0] bfs_reg [AXES], bfs_next [AXES];
    logic signed [VALUE_WIDTH-1:0] cr_reg  [AXES], cr_next  [AXES];
    logic signed [VALUE_WIDTH-1:0] t_reg, t_next;
    div_lane_t                     lane_reg [LANES], lane_next [LANES];
    logic [DT_WIDTH-1:0]           dt_reg, dt_next;
    logic                          sat_reg, sat_next;
    logic [PROD_WIDTH-1:0]         prod_reg, prod_next;
    logic                          prod_neg_reg, prod_neg_next;
    out_item_t                     out_reg, out_next;

    logic signed [VALUE_WIDTH-1:0] op_a;
    logic signed [VALUE_WIDTH-1:0] vec [AXES];
    logic [VALUE_WIDTH-1:0]        mag_b;
    logic                          neg_b;
    sat_val_t                      q;

    assign vec[0] = s_data.vec_x;
    assign vec[1] = s_data.vec_y;
    assign vec[2] = s_data.vec_z;

    assign stat.is_tick = (s_data.mode == MODE_TICK);
    assign m_data       = out_reg;

    // Operand A selection.
    always_comb begin
        case (cmd.uop.a)
            A_VEL0:  op_a = vel_reg[0];
            A_VEL1:  op_a = vel_reg[1];
            A_VEL2:  op_a = vel_reg[2];
            A_ACC0:  op_a = acc_reg[0];
            A_ACC1:  op_a = acc_reg[1];
            A_ACC2:  op_a = acc_reg[2];
            A_CHG:   op_a = charge;
            A_F0:    op_a = frc_reg[0];
            A_F1:    op_a = frc_reg[1];
            A_F2:    op_a = frc_reg[2];
            default: op_a = '0;
        endcase
    end

    // Operand B selection, as magnitude and sign.
    always_comb begin
        neg_b = 1'b0;
        mag_b = '0;
        case (cmd.uop.b)
            B_B0: begin
                neg_b = bfs_reg[0][VALUE_WIDTH-1]; mag_b = magn(bfs_reg[0]);
            end
            B_B1: begin
                neg_b = bfs_reg[1][VALUE_WIDTH-1]; mag_b = magn(bfs_reg[1]);
            end
            B_B2: begin
                neg_b = bfs_reg[2][VALUE_WIDTH-1]; mag_b = magn(bfs_reg[2]);
            end
            B_CR0: begin
                neg_b = cr_reg[0][VALUE_WIDTH-1]; mag_b = magn(cr_reg[0]);
            end
            B_CR1: begin
                neg_b = cr_reg[1][VALUE_WIDTH-1]; mag_b = magn(cr_reg[1]);
            end
            B_CR2: begin
                neg_b = cr_reg[2][VALUE_WIDTH-1]; mag_b = magn(cr_reg[2]);
            end
            B_DT:    mag_b = VALUE_WIDTH'(dt_reg);
            B_IM:    mag_b = VALUE_WIDTH'(inv_mass);
            default: mag_b = '0;
        endcase
    end

    // Shared magnitude multiplier, registered.
    assign prod_next     = PROD_WIDTH'(magn(op_a)) * PROD_WIDTH'(mag_b);
    assign prod_neg_next = op_a[VALUE_WIDTH-1] ^ neg_b;

    // Fixed-point product of the previous step: drop the fraction bits and clip.
    assign q = sat_mag(SAT_WIDTH'(prod_reg[PROD_WIDTH-1:FRACTION_BITS]), prod_neg_reg);

    // State update for requests, microprogram steps and result loading.
    always_comb begin
        sat_val_t r;
        logic     flag;
        pos_next  = pos_reg;
        vel_next  = vel_reg;
        acc_next  = acc_reg;
        frc_next  = frc_reg;
        efs_next  = efs_reg;
        bfs_next  = bfs_reg;
        cr_next   = cr_reg;
        t_next    = t_reg;
        lane_next = lane_reg;
        dt_next   = dt_reg;
        out_next  = out_reg;
        flag      = 1'b0;
        r         = '0;

        // Requests taken from the input channel.
        if (cmd.accept) begin
            case (s_data.mode)
                MODE_ADD_FORCE: begin
                    for (int i = 0; i < AXES; i++) begin
                        r = sat_add(frc_reg[i], vec[i]);
                        frc_next[i] = r.val;
                    end
                end
                MODE_ADD_EFIELD: begin
                    for (int i = 0; i < AXES; i++) begin
                        r = sat_add(efs_reg[i], vec[i]);
                        efs_next[i] = r.val;
                    end
                end
                MODE_ADD_BFIELD: begin
                    for (int i = 0; i < AXES; i++) begin
                        r = sat_add(bfs_reg[i], vec[i]);
                        bfs_next[i] = r.val;
                    end
                end
                MODE_LOAD_POS: pos_next = vec;
                MODE_LOAD_VEL: vel_next = vec;
                MODE_LOAD_ACC: acc_next = vec;
                MODE_TICK:     dt_next = s_data.dt_ms;
                default: ;
            endcase
        end

        // Place the previous product.
        case (cmd.uop.post)
            P_T: begin
                t_next = q.val;
                flag   = q.sat;
            end
            P_CR0, P_CR1, P_CR2: begin
                r = sat_sub(t_reg, q.val);
                flag = q.sat | r.sat;
                if (cmd.uop.post == P_CR0) begin
                    cr_next[0] = r.val;
                end else if (cmd.uop.post == P_CR1) begin
                    cr_next[1] = r.val;
                end else begin
                    cr_next[2] = r.val;
                end
            end
            P_F0: begin
                r = sat_add(frc_reg[0], q.val);
                frc_next[0] = r.val;
                flag = q.sat | r.sat;
            end
            P_F1: begin
                r = sat_add(frc_reg[1], q.val);
                frc_next[1] = r.val;
                flag = q.sat | r.sat;
            end
            P_F2: begin
                r = sat_add(frc_reg[2], q.val);
                frc_next[2] = r.val;
                flag = q.sat | r.sat;
            end
            P_ACC0: begin
                acc_next[0] = q.val;
                flag        = q.sat;
            end
            P_ACC1: begin
                acc_next[1] = q.val;
                flag        = q.sat;
            end
            P_ACC2: begin
                acc_next[2] = q.val;
                flag        = q.sat;
            end
            P_W0: lane_next[0] = '{neg: prod_neg_reg, quo: prod_reg[SCALE_WIDTH-1:0], rem: '0};
            P_W1: lane_next[1] = '{neg: prod_neg_reg, quo: prod_reg[SCALE_WIDTH-1:0], rem: '0};
            P_W2: lane_next[2] = '{neg: prod_neg_reg, quo: prod_reg[SCALE_WIDTH-1:0], rem: '0};
            P_W3: lane_next[3] = '{neg: prod_neg_reg, quo: prod_reg[SCALE_WIDTH-1:0], rem: '0};
            P_W4: lane_next[4] = '{neg: prod_neg_reg, quo: prod_reg[SCALE_WIDTH-1:0], rem: '0};
            P_W5: lane_next[5] = '{neg: prod_neg_reg, quo: prod_reg[SCALE_WIDTH-1:0], rem: '0};
            default: ;
        endcase

        // Operations across all lanes.
        case (cmd.uop.lane)
            L_ADDE: begin
                for (int i = 0; i < AXES; i++) begin
                    r = sat_add(efs_reg[i], cr_reg[i]);
                    cr_next[i] = r.val;
                    flag = flag | r.sat;
                end
            end
            L_DIV: begin
                for (int k = 0; k < LANES; k++) begin
                    lane_next[k] = div_step(lane_reg[k]);
                end
            end
            L_DSAT: begin
                for (int k = 0; k < LANES; k++) begin
                    r = sat_mag(SAT_WIDTH'(lane_reg[k].quo), lane_reg[k].neg);
                    lane_next[k].quo = {{(SCALE_WIDTH-VALUE_WIDTH){r.val[VALUE_WIDTH-1]}}, r.val};
                    flag = flag | r.sat;
                end
            end
            L_DADD: begin
                for (int i = 0; i < AXES; i++) begin
                    r = sat_add(pos_reg[i], lane_reg[i].quo[VALUE_WIDTH-1:0]);
                    pos_next[i] = r.val;
                    flag = flag | r.sat;
                    r = sat_add(vel_reg[i], lane_reg[i+AXES].quo[VALUE_WIDTH-1:0]);
                    vel_next[i] = r.val;
                    flag = flag | r.sat;
                end
            end
            default: ;
        endcase

        // Load the result and clear the accumulators at the end of a tick.
        if (cmd.emit) begin
            out_next.pos_x     = pos_reg[0];
            out_next.pos_y     = pos_reg[1];
            out_next.pos_z     = pos_reg[2];
            out_next.vel_x     = vel_reg[0];
            out_next.vel_y     = vel_reg[1];
            out_next.vel_z     = vel_reg[2];
            out_next.acc_x     = acc_reg[0];
            out_next.acc_y     = acc_reg[1];
            out_next.acc_z     = acc_reg[2];
            out_next.saturated = sat_reg;
            for (int i = 0; i < AXES; i++) begin
                frc_next[i] = '0;
                efs_next[i] = '0;
                bfs_next[i] = '0;
            end
        end

        // A new tick starts with a clean clip flag.
        if (cmd.accept && stat.is_tick) begin
            sat_next = 1'b0;
        end else begin
            sat_next = sat_reg | flag;
        end
    end

    // Architectural state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AXES; i++) begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
                acc_reg[i] <= '0;
                frc_reg[i] <= '0;
                efs_reg[i] <= '0;
                bfs_reg[i] <= '0;
            end
            sat_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            vel_reg <= vel_next;
            acc_reg <= acc_next;
            frc_reg <= frc_next;
            efs_reg <= efs_next;
            bfs_reg <= bfs_next;
            sat_reg <= sat_next;
        end
    end

    // Working registers and the result register.
    always_ff @(posedge aclk) begin
        cr_reg       <= cr_next;
        t_reg        <= t_next;
        lane_reg     <= lane_next;
        dt_reg       <= dt_next;
        prod_reg     <= prod_next;
        prod_neg_reg <= prod_neg_next;
        out_reg      <= out_next;
    end

endmodule
